// ----- rtl/vbpc_pkg.sv -----
// vbpc_pkg: shared widths, constants, codes and helpers of the pixel classifier
// used by vbpc_match_unit and vibe_background_pixel_classifier_core
package vbpc_pkg;

	localparam int SAMPLES_PER_PIXEL_DEF = 20;
	localparam int MAX_WIDTH_DEF         = 640;
	localparam int MAX_HEIGHT_DEF        = 480;

	localparam int COORD_W      = 11;
	localparam int PIXEL_W      = 8;
	localparam int SLOT_W       = 5;
	localparam int DRAW_W       = 6;
	localparam int STALE_DRAW_W = 5;
	localparam int PICK_W       = 4;
	localparam int COUNT_W      = 6;
	localparam int RUN_W        = 8;
	localparam int CFG_DIM_W    = 12;
	localparam int RADIUS_W     = 8;
	localparam int REQ_W        = 6;
	localparam int CFG_DATA_W   = 12;
	localparam int CFG_IDX_W    = 2;

	// wide intermediates for pixel index and sample address arithmetic
	localparam int PIX_WIDE_W  = 24;
	localparam int ADDR_WIDE_W = 28;

	localparam logic [RUN_W-1:0] STALE_LIMIT = 8'd50;
	localparam logic [RUN_W-1:0] RUN_MAX     = 8'd255;

	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MATCH_RADIUS     = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_REQUIRED_MATCHES = 2'd3;

	localparam logic [CFG_DIM_W-1:0] FRAME_WIDTH_RST      = 12'd640;
	localparam logic [CFG_DIM_W-1:0] FRAME_HEIGHT_RST     = 12'd480;
	localparam logic [RADIUS_W-1:0]  MATCH_RADIUS_RST     = 8'd20;
	localparam logic [REQ_W-1:0]     REQUIRED_MATCHES_RST = 6'd2;

	localparam logic FUNC_LOAD     = 1'b0;
	localparam logic FUNC_CLASSIFY = 1'b1;

	typedef struct packed {
		logic start;
		logic valid;
		logic last;
	} match_ctl_t;

	// neighbor offset table, picks above eight give no offset
	function automatic logic signed [1:0] pick_offset(input logic [PICK_W-1:0] pick);
		logic signed [1:0] off;
		case (pick)
			4'd0: off = -2'sd1;
			4'd1: off = 2'sd0;
			4'd2: off = 2'sd1;
			4'd3: off = -2'sd1;
			4'd4: off = 2'sd1;
			4'd5: off = -2'sd1;
			4'd6: off = 2'sd0;
			4'd7: off = 2'sd1;
			4'd8: off = 2'sd0;
			default: off = 2'sd0;
		endcase
		return off;
	endfunction

	function automatic logic [COORD_W-1:0] clamp_coord(input logic [COORD_W-1:0] base,
			input logic signed [1:0] off, input logic [CFG_DIM_W-1:0] limit);
		logic signed [COORD_W+1:0] v;
		logic [CFG_DIM_W-1:0] lim_m1;
		logic [COORD_W-1:0] res;
		v = signed'({2'b00, base}) + (COORD_W+2)'(off);
		lim_m1 = limit - 12'd1;
		if (v < 0) begin
			res = '0;
		end else if (v >= signed'({1'b0, limit})) begin
			res = lim_m1[COORD_W-1:0];
		end else begin
			res = v[COORD_W-1:0];
		end
		return res;
	endfunction

endpackage

// ----- rtl/vbpc_match_unit.sv -----
// vbpc_match_unit: shared grey-level compare and match counter, one sample a beat
// depends on vbpc_pkg
module vbpc_match_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  vbpc_pkg::match_ctl_t              ctl,
	input  logic [vbpc_pkg::PIXEL_W-1:0]      pixel,
	input  logic [vbpc_pkg::PIXEL_W-1:0]      sample,
	input  logic [vbpc_pkg::RADIUS_W-1:0]     radius,
	input  logic [vbpc_pkg::REQ_W-1:0]        required,
	output logic [vbpc_pkg::COUNT_W-1:0]      count,
	output logic                              stop
);

	logic [vbpc_pkg::COUNT_W-1:0] count_q;
	logic [vbpc_pkg::COUNT_W-1:0] count_nx;
	logic [vbpc_pkg::PIXEL_W-1:0] diff;
	logic                         hit;

	always_comb begin
		diff = (pixel >= sample) ? (pixel - sample) : (sample - pixel);
		hit = diff < radius;
		count_nx = count_q + vbpc_pkg::COUNT_W'(hit);
		stop = ctl.valid && ((count_nx >= required) || ctl.last);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctl.start) begin
			count_q <= '0;
		end else if (ctl.valid) begin
			count_q <= count_nx;
		end
	end

	assign count = count_q;

`ifndef SYNTHESIS
	a_count_below_required: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.valid |-> (count_q < required))
		else $error("match count reached required yet scan continued");
	a_start_clears: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.start |=> (count_q == '0))
		else $error("match count not cleared by start");
	a_count_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(!$past(ctl.start) && !$past(ctl.valid)) |-> $stable(count_q))
		else $error("match count changed without a sample");
`endif

endmodule

// ----- rtl/vibe_background_pixel_classifier_core.sv -----
// vibe_background_pixel_classifier_core: per-pixel sample store, run counters and sequencer
// depends on vbpc_pkg and vbpc_match_unit
//
// channel  | handshake              | payload
// in       | in_valid / in_stall    | func col row pixel slot draws picks slots
// out      | out_valid / out_stall  | is_foreground match_count
// cfg      | cfg_we                 | cfg_index cfg_data
//
// a load beat passes CALC, BASE and LOAD; a classify beat passes CALC, BASE, SCAN over
// the samples, UPD1, UPD2 and RESP (no SCAN with no match required); the scan is paced
// by the single read port of the sample memory
// after reset the run counters are cleared, in_stall high
// the sample memory is never cleared; a read of a never loaded sample is undefined
// a result waiting under out_stall holds the block before its next result only
module vibe_background_pixel_classifier_core #(
	parameter int SAMPLES_PER_PIXEL = vbpc_pkg::SAMPLES_PER_PIXEL_DEF,
	parameter int MAX_WIDTH         = vbpc_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT        = vbpc_pkg::MAX_HEIGHT_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic                                 func,
	input  logic [vbpc_pkg::COORD_W-1:0]         col,
	input  logic [vbpc_pkg::COORD_W-1:0]         row,
	input  logic [vbpc_pkg::PIXEL_W-1:0]         pixel,
	input  logic [vbpc_pkg::SLOT_W-1:0]          slot,
	input  logic [vbpc_pkg::DRAW_W-1:0]          self_draw,
	input  logic [vbpc_pkg::DRAW_W-1:0]          neighbor_draw,
	input  logic [vbpc_pkg::PICK_W-1:0]          neighbor_row_pick,
	input  logic [vbpc_pkg::PICK_W-1:0]          neighbor_col_pick,
	input  logic [vbpc_pkg::SLOT_W-1:0]          neighbor_slot,
	input  logic [vbpc_pkg::STALE_DRAW_W-1:0]    stale_draw,
	input  logic [vbpc_pkg::SLOT_W-1:0]          stale_slot,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic                                 is_foreground,
	output logic [vbpc_pkg::COUNT_W-1:0]         match_count,
	input  logic                                 cfg_we,
	input  logic [vbpc_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [vbpc_pkg::CFG_DATA_W-1:0]      cfg_data
);

	localparam int PIX_COUNT  = MAX_WIDTH * MAX_HEIGHT;
	localparam int PIX_AW     = (PIX_COUNT > 1) ? $clog2(PIX_COUNT) : 1;
	localparam int SAMP_DEPTH = PIX_COUNT * SAMPLES_PER_PIXEL;
	localparam int SAMP_AW    = $clog2(SAMP_DEPTH);
	localparam int IDX_W      = $clog2(SAMPLES_PER_PIXEL + 1);

	localparam logic [vbpc_pkg::CFG_DIM_W-1:0] MAXW_C =
		vbpc_pkg::CFG_DIM_W'(MAX_WIDTH);
	localparam logic [vbpc_pkg::CFG_DIM_W-1:0] MAXH_C =
		vbpc_pkg::CFG_DIM_W'(MAX_HEIGHT);
	localparam logic [vbpc_pkg::PIX_WIDE_W-1:0] MAXW_WIDE =
		vbpc_pkg::PIX_WIDE_W'(MAX_WIDTH);
	localparam logic [vbpc_pkg::ADDR_WIDE_W-1:0] N_WIDE =
		vbpc_pkg::ADDR_WIDE_W'(SAMPLES_PER_PIXEL);
	localparam logic [vbpc_pkg::SLOT_W:0] N_SLOT =
		(vbpc_pkg::SLOT_W+1)'(SAMPLES_PER_PIXEL);
	localparam logic [IDX_W-1:0] N_IDX      = IDX_W'(SAMPLES_PER_PIXEL);
	localparam logic [IDX_W-1:0] N_IDX_LAST = IDX_W'(SAMPLES_PER_PIXEL - 1);
	localparam logic [PIX_AW-1:0] PIX_LAST  = PIX_AW'(PIX_COUNT - 1);

	typedef enum logic [8:0] {
		ST_CLEAR = 9'b000000001,
		ST_IDLE  = 9'b000000010,
		ST_CALC  = 9'b000000100,
		ST_BASE  = 9'b000001000,
		ST_LOAD  = 9'b000010000,
		ST_SCAN  = 9'b000100000,
		ST_UPD1  = 9'b001000000,
		ST_UPD2  = 9'b010000000,
		ST_RESP  = 9'b100000000
	} state_t;

	state_t state_q;

	// configuration
	logic [vbpc_pkg::CFG_DIM_W-1:0] frame_width_q;
	logic [vbpc_pkg::CFG_DIM_W-1:0] frame_height_q;
	logic [vbpc_pkg::RADIUS_W-1:0]  match_radius_q;
	logic [vbpc_pkg::REQ_W-1:0]     required_matches_q;

	// captured beat
	logic                              func_q;
	logic [vbpc_pkg::COORD_W-1:0]      col_q;
	logic [vbpc_pkg::COORD_W-1:0]      row_q;
	logic [vbpc_pkg::PIXEL_W-1:0]      pixel_q;
	logic [vbpc_pkg::SLOT_W-1:0]       slot_q;
	logic [vbpc_pkg::DRAW_W-1:0]       self_draw_q;
	logic [vbpc_pkg::DRAW_W-1:0]       nb_draw_q;
	logic [vbpc_pkg::PICK_W-1:0]       nb_row_pick_q;
	logic [vbpc_pkg::PICK_W-1:0]       nb_col_pick_q;
	logic [vbpc_pkg::SLOT_W-1:0]       nb_slot_q;
	logic [vbpc_pkg::STALE_DRAW_W-1:0] stale_draw_q;
	logic [vbpc_pkg::SLOT_W-1:0]       stale_slot_q;

	// address path
	logic [PIX_AW-1:0]  pix_q;
	logic [PIX_AW-1:0]  nb_pix_q;
	logic [SAMP_AW-1:0] base_q;
	logic [SAMP_AW-1:0] nb_base_q;
	logic [PIX_AW-1:0]  clr_idx_q;
	logic [IDX_W-1:0]   iss_idx_q;
	logic               rd_vld_s1;
	logic               rd_last_s1;

	logic [vbpc_pkg::CFG_DIM_W-1:0] w_raw, h_raw, w_eff, h_eff;
	logic in_accept, in_range;
	logic [vbpc_pkg::COORD_W-1:0]    nb_row, nb_col;
	logic [vbpc_pkg::PIX_WIDE_W-1:0] pix_wide, nb_pix_wide;
	logic [vbpc_pkg::ADDR_WIDE_W-1:0] base_wide, nb_base_wide, rd_wide, wr_wide;
	logic [vbpc_pkg::ADDR_WIDE_W-1:0] self_wide, stale_wide, nb_wr_wide;
	logic issue;

	// memories
	logic [vbpc_pkg::PIXEL_W-1:0] samp_mem [SAMP_DEPTH];
	logic [vbpc_pkg::RUN_W-1:0]   fg_mem [PIX_COUNT];
	logic [vbpc_pkg::PIXEL_W-1:0] samp_rd_q;
	logic [vbpc_pkg::RUN_W-1:0]   fg_rd_q;

	logic                         samp_we;
	logic [SAMP_AW-1:0]           samp_waddr;
	logic                         fg_we;
	logic [PIX_AW-1:0]            fg_waddr;
	logic [vbpc_pkg::RUN_W-1:0]   fg_wdata;

	// match unit
	vbpc_pkg::match_ctl_t         mctl;
	logic [vbpc_pkg::COUNT_W-1:0] mcount;
	logic                         mstop;

	logic                       bg;
	logic [vbpc_pkg::RUN_W-1:0] run_nx;
	logic                       self_en, stale_en, nb_en, slot_ok, stale_ok, nb_ok;

	// output register
	logic                         out_valid_q;
	logic                         is_fg_q;
	logic [vbpc_pkg::COUNT_W-1:0] mc_q;
	logic                         out_load;

	always_comb begin
		w_raw = (frame_width_q == '0) ? 12'd1 : frame_width_q;
		h_raw = (frame_height_q == '0) ? 12'd1 : frame_height_q;
		w_eff = (w_raw > MAXW_C) ? MAXW_C : w_raw;
		h_eff = (h_raw > MAXH_C) ? MAXH_C : h_raw;
		in_range = ({1'b0, col} < w_eff) && ({1'b0, row} < h_eff);
		in_stall = (state_q != ST_IDLE);
		in_accept = in_valid && !in_stall;

		nb_row = vbpc_pkg::clamp_coord(row_q, vbpc_pkg::pick_offset(nb_row_pick_q), h_eff);
		nb_col = vbpc_pkg::clamp_coord(col_q, vbpc_pkg::pick_offset(nb_col_pick_q), w_eff);
		pix_wide = vbpc_pkg::PIX_WIDE_W'(row_q) * MAXW_WIDE + vbpc_pkg::PIX_WIDE_W'(col_q);
		nb_pix_wide = vbpc_pkg::PIX_WIDE_W'(nb_row) * MAXW_WIDE
			+ vbpc_pkg::PIX_WIDE_W'(nb_col);
		base_wide = vbpc_pkg::ADDR_WIDE_W'(pix_q) * N_WIDE;
		nb_base_wide = vbpc_pkg::ADDR_WIDE_W'(nb_pix_q) * N_WIDE;

		rd_wide = vbpc_pkg::ADDR_WIDE_W'(base_q) + vbpc_pkg::ADDR_WIDE_W'(iss_idx_q);
		self_wide = vbpc_pkg::ADDR_WIDE_W'(base_q) + vbpc_pkg::ADDR_WIDE_W'(slot_q);
		stale_wide = vbpc_pkg::ADDR_WIDE_W'(base_q) + vbpc_pkg::ADDR_WIDE_W'(stale_slot_q);
		nb_wr_wide = vbpc_pkg::ADDR_WIDE_W'(nb_base_q) + vbpc_pkg::ADDR_WIDE_W'(nb_slot_q);

		issue = (state_q == ST_SCAN) && (iss_idx_q < N_IDX);

		mctl.start = (state_q == ST_BASE);
		mctl.valid = (state_q == ST_SCAN) && rd_vld_s1;
		mctl.last = rd_last_s1;

		bg = mcount >= required_matches_q;
		run_nx = (fg_rd_q == vbpc_pkg::RUN_MAX) ? fg_rd_q : (fg_rd_q + 8'd1);
		slot_ok = {1'b0, slot_q} < N_SLOT;
		stale_ok = {1'b0, stale_slot_q} < N_SLOT;
		nb_ok = {1'b0, nb_slot_q} < N_SLOT;
		self_en = bg && (self_draw_q == '0) && slot_ok;
		stale_en = !bg && (run_nx > vbpc_pkg::STALE_LIMIT) && (stale_draw_q == '0)
			&& stale_ok;
		nb_en = bg && (nb_draw_q == '0) && nb_ok;

		samp_we = 1'b0;
		wr_wide = self_wide;
		fg_we = 1'b0;
		fg_waddr = pix_q;
		fg_wdata = '0;
		case (state_q)
			ST_CLEAR: begin
				fg_we = 1'b1;
				fg_waddr = clr_idx_q;
			end
			ST_LOAD: begin
				samp_we = slot_ok;
				fg_we = 1'b1;
			end
			ST_UPD1: begin
				samp_we = self_en || stale_en;
				wr_wide = bg ? self_wide : stale_wide;
				fg_we = 1'b1;
				fg_wdata = bg ? '0 : run_nx;
			end
			ST_UPD2: begin
				samp_we = nb_en;
				wr_wide = nb_wr_wide;
			end
			default: begin
				samp_we = 1'b0;
			end
		endcase
		samp_waddr = wr_wide[SAMP_AW-1:0];

		out_load = (state_q == ST_RESP) && (!out_valid_q || !out_stall);
	end

	vbpc_match_unit u_match (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (mctl),
		.pixel    (pixel_q),
		.sample   (samp_rd_q),
		.radius   (match_radius_q),
		.required (required_matches_q),
		.count    (mcount),
		.stop     (mstop)
	);

	always_ff @(posedge clk) begin
		if (samp_we) begin
			samp_mem[samp_waddr] <= pixel_q;
		end
		if (issue) begin
			samp_rd_q <= samp_mem[rd_wide[SAMP_AW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (fg_we) begin
			fg_mem[fg_waddr] <= fg_wdata;
		end
		if (state_q == ST_BASE) begin
			fg_rd_q <= fg_mem[pix_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q <= vbpc_pkg::FRAME_WIDTH_RST;
			frame_height_q <= vbpc_pkg::FRAME_HEIGHT_RST;
			match_radius_q <= vbpc_pkg::MATCH_RADIUS_RST;
			required_matches_q <= vbpc_pkg::REQUIRED_MATCHES_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				vbpc_pkg::CFG_FRAME_WIDTH: frame_width_q <= cfg_data;
				vbpc_pkg::CFG_FRAME_HEIGHT: frame_height_q <= cfg_data;
				vbpc_pkg::CFG_MATCH_RADIUS: match_radius_q <= cfg_data[vbpc_pkg::RADIUS_W-1:0];
				vbpc_pkg::CFG_REQUIRED_MATCHES: begin
					required_matches_q <= cfg_data[vbpc_pkg::REQ_W-1:0];
				end
				default: begin
					frame_width_q <= frame_width_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			func_q <= func;
			col_q <= col;
			row_q <= row;
			pixel_q <= pixel;
			slot_q <= slot;
			self_draw_q <= self_draw;
			nb_draw_q <= neighbor_draw;
			nb_row_pick_q <= neighbor_row_pick;
			nb_col_pick_q <= neighbor_col_pick;
			nb_slot_q <= neighbor_slot;
			stale_draw_q <= stale_draw;
			stale_slot_q <= stale_slot;
		end
		if (state_q == ST_CALC) begin
			pix_q <= pix_wide[PIX_AW-1:0];
			nb_pix_q <= nb_pix_wide[PIX_AW-1:0];
		end
		if (state_q == ST_BASE) begin
			base_q <= base_wide[SAMP_AW-1:0];
			nb_base_q <= nb_base_wide[SAMP_AW-1:0];
		end
		if (out_load) begin
			is_fg_q <= !bg;
			mc_q <= mcount;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_idx_q <= '0;
			iss_idx_q <= '0;
			rd_vld_s1 <= 1'b0;
			rd_last_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_vld_s1 <= issue;
			rd_last_s1 <= (iss_idx_q == N_IDX_LAST);
			if (issue) begin
				iss_idx_q <= iss_idx_q + 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_idx_q <= clr_idx_q + 1'b1;
					if (clr_idx_q == PIX_LAST) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_accept && in_range) begin
						state_q <= ST_CALC;
					end
				end
				ST_CALC: begin
					state_q <= ST_BASE;
				end
				ST_BASE: begin
					iss_idx_q <= '0;
					if (func_q == vbpc_pkg::FUNC_LOAD) begin
						state_q <= ST_LOAD;
					end else if (required_matches_q == '0) begin
						state_q <= ST_UPD1;
					end else begin
						state_q <= ST_SCAN;
					end
				end
				ST_LOAD: begin
					state_q <= ST_IDLE;
				end
				ST_SCAN: begin
					if (mstop) begin
						state_q <= ST_UPD1;
					end
				end
				ST_UPD1: begin
					state_q <= ST_UPD2;
				end
				ST_UPD2: begin
					state_q <= ST_RESP;
				end
				ST_RESP: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign is_foreground = is_fg_q;
	assign match_count = mc_q;

`ifndef SYNTHESIS
	a_result_from_resp: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_RESP))
		else $error("result raised outside the response step");
	a_out_of_frame_dropped: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && in_valid && !in_range) |=> (state_q == ST_IDLE))
		else $error("out of frame beat started work");
	a_scan_index_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (iss_idx_q <= N_IDX))
		else $error("sample index ran past the pixel's samples");
	a_neighbor_after_own: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UPD2) |-> $past(state_q == ST_UPD1))
		else $error("neighbor update without own update");
`endif

endmodule
